FILE: rtl/core/dtp_pkg.sv
package dtp_pkg;

   // Field widths
   localparam int YEAR_W  = 14;
   localparam int FIELD_W = 7;
   localparam int PIVOT_W = 7;

   // Character codes
   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Range limits
   localparam logic [YEAR_W-1:0]  YEAR_1900  = 14'd1900;
   localparam logic [YEAR_W-1:0]  YEAR_2000  = 14'd2000;
   localparam logic [FIELD_W-1:0] MAX_MONTH  = 7'd12;
   localparam logic [FIELD_W-1:0] MAX_DAY    = 7'd31;
   localparam logic [FIELD_W-1:0] MAX_HOUR   = 7'd23;
   localparam logic [FIELD_W-1:0] MAX_MINSEC = 7'd59;
   localparam logic [PIVOT_W-1:0] PIVOT_RESET = 7'd50;

   // Compact form lengths and field boundaries
   localparam int LEN_DATE   = 8;
   localparam int LEN_HM     = 12;
   localparam int LEN_HMS    = 14;
   localparam int LEN_MSEC   = 17;
   localparam int POS_MONTH  = 4;
   localparam int POS_DAY    = 6;
   localparam int POS_HOUR   = 8;
   localparam int POS_MINUTE = 10;
   localparam int POS_SECOND = 12;

   typedef enum logic [4:0] {
      PH_START, PH_LEAD2, PH_LEAD3, PH_DAY1, PH_DAY2, PH_DAYSL,
      PH_Y1, PH_Y2, PH_Y3, PH_Y4, PH_YEND,
      PH_H1, PH_H2, PH_HC, PH_M1, PH_M2, PH_MEND, PH_S1, PH_S2, PH_SEND,
      PH_COMPACT
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic        text_form;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } rsp_type;

   // Parse state after the current byte, seen by the end check
   typedef struct packed {
      phase_type          phase;
      logic               error;
      logic               form;
      logic               len_ok;
      logic [YEAR_W-1:0]  accum;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } view_type;

   function automatic logic [YEAR_W-1:0] map_year(input logic [PIVOT_W-1:0] yy,
                                                  input logic [PIVOT_W-1:0] pivot);
      logic [YEAR_W-1:0] base;
      base = (yy < pivot) ? YEAR_2000 : YEAR_1900;
      return base + YEAR_W'(yy);
   endfunction

   function automatic logic [YEAR_W-1:0] ten_add(input logic [YEAR_W-1:0] a,
                                                 input logic [3:0] d);
      return (a << 3) + (a << 1) + YEAR_W'(d);
   endfunction

endpackage

FILE: rtl/core/dtp_parse.sv
module dtp_parse
   import dtp_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_accept,
   input  req_type            item,
   input  logic [PIVOT_W-1:0] pivot,
   output view_type           view
);

   localparam int CNT_W = $clog2(MAX_TEXT_LEN + 1);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [YEAR_W-1:0]  accum_ff, accum_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [FIELD_W-1:0] month_ff, month_in;
   logic [FIELD_W-1:0] day_ff, day_in;
   logic [FIELD_W-1:0] hour_ff, hour_in;
   logic [FIELD_W-1:0] minute_ff, minute_in;
   logic [FIELD_W-1:0] second_ff, second_in;
   logic               error_ff, error_in;
   logic               ended_ff, ended_in;
   logic               form_ff, form_in;

   logic               is_digit;
   logic [3:0]         digit;
   logic [YEAR_W-1:0]  acc_ten;
   logic [FIELD_W-1:0] acc_ten_f;
   logic               bad;
   logic [7:0]         c;

   assign c         = item.text_byte;
   assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign digit     = is_digit ? 4'(c - CHAR_ZERO) : 4'd0;
   assign acc_ten   = ten_add(accum_ff, digit);
   assign acc_ten_f = FIELD_W'(acc_ten);

   // Advance the parse by one byte
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      error_in  = error_ff;
      ended_in  = ended_ff;
      form_in   = form_ff;
      bad       = 1'b0;
      if (!ended_ff) begin
         if (c == CHAR_END) begin
            ended_in = 1'b1;
         end else if (count_ff >= CNT_W'(MAX_TEXT_LEN)) begin
            error_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            if (!error_ff) begin
               case (phase_ff)
                  PH_START: begin
                     if (is_digit) begin
                        accum_in = YEAR_W'(digit);
                        phase_in = PH_LEAD2;
                     end else bad = 1'b1;
                  end
                  PH_LEAD2: begin
                     if (c == CHAR_SLASH) begin
                        if (accum_ff == '0) bad = 1'b1;
                        month_in = FIELD_W'(accum_ff);
                        phase_in = PH_DAY1;
                     end else if (is_digit) begin
                        accum_in = acc_ten;
                        phase_in = PH_LEAD3;
                     end else bad = 1'b1;
                  end
                  PH_LEAD3: begin
                     if (c == CHAR_SLASH) begin
                        if (accum_ff == '0 || accum_ff > YEAR_W'(MAX_MONTH)) bad = 1'b1;
                        month_in = FIELD_W'(accum_ff);
                        phase_in = PH_DAY1;
                     end else if (is_digit) begin
                        form_in  = 1'b1;
                        year_in  = acc_ten;
                        phase_in = PH_COMPACT;
                     end else bad = 1'b1;
                  end
                  PH_DAY1: begin
                     if (is_digit) begin
                        accum_in = YEAR_W'(digit);
                        phase_in = PH_DAY2;
                     end else bad = 1'b1;
                  end
                  PH_DAY2: begin
                     if (c == CHAR_SLASH) begin
                        if (accum_ff == '0) bad = 1'b1;
                        day_in   = FIELD_W'(accum_ff);
                        phase_in = PH_Y1;
                     end else if (is_digit) begin
                        accum_in = acc_ten;
                        phase_in = PH_DAYSL;
                     end else bad = 1'b1;
                  end
                  PH_DAYSL: begin
                     if (c == CHAR_SLASH) begin
                        if (accum_ff == '0 || accum_ff > YEAR_W'(MAX_DAY)) bad = 1'b1;
                        day_in   = FIELD_W'(accum_ff);
                        phase_in = PH_Y1;
                     end else bad = 1'b1;
                  end
                  PH_Y1: begin
                     if (is_digit) begin
                        accum_in = YEAR_W'(digit);
                        phase_in = PH_Y2;
                     end else bad = 1'b1;
                  end
                  PH_Y2: begin
                     if (is_digit) begin
                        accum_in = acc_ten;
                        phase_in = PH_Y3;
                     end else bad = 1'b1;
                  end
                  PH_Y3: begin
                     if (c == CHAR_SPACE) begin
                        year_in  = map_year(PIVOT_W'(accum_ff), pivot);
                        phase_in = PH_H1;
                     end else if (is_digit) begin
                        accum_in = acc_ten;
                        phase_in = PH_Y4;
                     end else bad = 1'b1;
                  end
                  PH_Y4: begin
                     if (is_digit) begin
                        accum_in = acc_ten;
                        phase_in = PH_YEND;
                     end else bad = 1'b1;
                  end
                  PH_YEND: begin
                     if (c == CHAR_SPACE) begin
                        year_in  = accum_ff;
                        phase_in = PH_H1;
                     end else bad = 1'b1;
                  end
                  PH_H1: begin
                     if (is_digit) begin
                        accum_in = YEAR_W'(digit);
                        phase_in = PH_H2;
                     end else bad = 1'b1;
                  end
                  PH_H2: begin
                     if (is_digit) begin
                        if (acc_ten_f > MAX_HOUR) bad = 1'b1;
                        hour_in  = acc_ten_f;
                        phase_in = PH_HC;
                     end else bad = 1'b1;
                  end
                  PH_HC: begin
                     if (c == CHAR_COLON) phase_in = PH_M1;
                     else bad = 1'b1;
                  end
                  PH_M1: begin
                     if (is_digit) begin
                        accum_in = YEAR_W'(digit);
                        phase_in = PH_M2;
                     end else bad = 1'b1;
                  end
                  PH_M2: begin
                     if (is_digit) begin
                        if (acc_ten_f > MAX_MINSEC) bad = 1'b1;
                        minute_in = acc_ten_f;
                        phase_in  = PH_MEND;
                     end else bad = 1'b1;
                  end
                  PH_MEND: begin
                     if (c == CHAR_COLON) phase_in = PH_S1;
                     else bad = 1'b1;
                  end
                  PH_S1: begin
                     if (is_digit) begin
                        accum_in = YEAR_W'(digit);
                        phase_in = PH_S2;
                     end else bad = 1'b1;
                  end
                  PH_S2: begin
                     if (is_digit) begin
                        if (acc_ten_f > MAX_MINSEC) bad = 1'b1;
                        second_in = acc_ten_f;
                        phase_in  = PH_SEND;
                     end else bad = 1'b1;
                  end
                  PH_COMPACT: begin
                     // route the digit to the field that its position selects
                     if (!is_digit) begin
                        bad = 1'b1;
                     end else if (count_ff < CNT_W'(POS_MONTH)) begin
                        year_in = ten_add(year_ff, digit);
                     end else if (count_ff < CNT_W'(POS_DAY)) begin
                        month_in = FIELD_W'(ten_add(YEAR_W'(month_ff), digit));
                     end else if (count_ff < CNT_W'(POS_HOUR)) begin
                        day_in = FIELD_W'(ten_add(YEAR_W'(day_ff), digit));
                     end else if (count_ff < CNT_W'(POS_MINUTE)) begin
                        hour_in = FIELD_W'(ten_add(YEAR_W'(hour_ff), digit));
                     end else if (count_ff < CNT_W'(POS_SECOND)) begin
                        minute_in = FIELD_W'(ten_add(YEAR_W'(minute_ff), digit));
                     end else if (count_ff < CNT_W'(LEN_HMS)) begin
                        second_in = FIELD_W'(ten_add(YEAR_W'(second_ff), digit));
                     end
                  end
                  default: bad = 1'b1;
               endcase
               if (bad) error_in = 1'b1;
            end
         end
      end
   end

   // Present the updated state to the end check
   always_comb begin
      view.phase  = phase_in;
      view.error  = error_in;
      view.form   = form_in;
      view.len_ok = (count_in == CNT_W'(LEN_DATE)) || (count_in == CNT_W'(LEN_HM)) ||
                    (count_in == CNT_W'(LEN_HMS)) || (count_in == CNT_W'(LEN_MSEC));
      view.accum  = accum_in;
      view.year   = year_in;
      view.month  = month_in;
      view.day    = day_in;
      view.hour   = hour_in;
      view.minute = minute_in;
      view.second = second_in;
   end

   // Hold state; clear it after the last byte of a text
   always_ff @(posedge clock) begin
      if (reset || (item_accept && item.last)) begin
         phase_ff  <= PH_START;
         count_ff  <= '0;
         accum_ff  <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         error_ff  <= 1'b0;
         ended_ff  <= 1'b0;
         form_ff   <= 1'b0;
      end else if (item_accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         error_ff  <= error_in;
         ended_ff  <= ended_in;
         form_ff   <= form_in;
      end
   end

endmodule

FILE: rtl/core/dtp_check.sv
module dtp_check
   import dtp_pkg::*;
(
   input  view_type           view,
   input  logic [PIVOT_W-1:0] pivot,
   output rsp_type            result
);

   logic              ok;
   logic [YEAR_W-1:0] year_out;

   // Decide whether the text ended at a complete, in-range point
   always_comb begin
      ok       = 1'b0;
      year_out = view.year;
      case (view.phase)
         PH_Y3: begin
            ok       = 1'b1;
            year_out = map_year(PIVOT_W'(view.accum), pivot);
         end
         PH_YEND: begin
            ok       = 1'b1;
            year_out = view.accum;
         end
         PH_MEND, PH_SEND: ok = 1'b1;
         PH_COMPACT: begin
            ok = view.len_ok && (view.year >= YEAR_1900) &&
                 (view.month != '0) && (view.month <= MAX_MONTH) &&
                 (view.day != '0) && (view.day <= MAX_DAY) &&
                 (view.hour <= MAX_HOUR) && (view.minute <= MAX_MINSEC) &&
                 (view.second <= MAX_MINSEC);
         end
         default: ok = 1'b0;
      endcase
      if (view.error) ok = 1'b0;
   end

   // Zero every field of an invalid result
   always_comb begin
      result           = '0;
      result.valid_res = ok;
      if (ok) begin
         result.text_form = view.form;
         result.year      = year_out;
         result.month     = 4'(view.month);
         result.day       = 5'(view.day);
         result.hour      = 5'(view.hour);
         result.minute    = 6'(view.minute);
         result.second    = 6'(view.second);
      end
   end

endmodule

FILE: rtl/core/date_time_text_parser_top.sv
// A result is registered and is on rsp_data in the cycle after the item carrying last is accepted.
// Throughput: one text byte per cycle while req_stall is low; one result per text.
// The parse state register and a result register are the only stages.
// Reset (synchronous, active high) clears the parse state and the result valid,
// and sets the year pivot to 50.
module date_time_text_parser_top
   import dtp_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [PIVOT_W-1:0] csr_wr_data
);

   logic [PIVOT_W-1:0] pivot_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               item_accept;
   view_type           view;
   rsp_type            result;

   // Stall only when a finished result is still waiting
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign item_accept = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   // Year pivot register
   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff <= PIVOT_RESET;
      end else if (csr_wr_en) begin
         pivot_ff <= csr_wr_data;
      end
   end

   dtp_parse #(
      .MAX_TEXT_LEN(MAX_TEXT_LEN)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .item        (req_data),
      .pivot       (pivot_ff),
      .view        (view)
   );

   dtp_check u_check (
      .view   (view),
      .pivot  (pivot_ff),
      .result (result)
   );

   // Load the result on the last byte; drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_accept && req_data.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept && req_data.last) begin
         rsp_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      item_accept && req_data.last |=> rsp_valid_ff)
      else $error("accepted last item produced no result");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.valid_res |-> rsp_ff.year == '0 && rsp_ff.month == '0 &&
         rsp_ff.day == '0 && rsp_ff.hour == '0 && rsp_ff.minute == '0 &&
         rsp_ff.second == '0 && !rsp_ff.text_form)
      else $error("invalid result carries nonzero fields");

   a_valid_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.valid_res |-> rsp_ff.month != '0 && rsp_ff.month <= 4'd12 &&
         rsp_ff.day != '0 && rsp_ff.hour <= 5'd23 && rsp_ff.minute <= 6'd59 &&
         rsp_ff.second <= 6'd59)
      else $error("valid result has a field out of range");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a waiting result");
`endif

endmodule

FILE: tb/dtp_tb_pkg.sv
package dtp_tb_pkg;
   import dtp_pkg::*;

   localparam int TEXT_LEN_MAX = 24;

   // Slots of the parsed field store
   typedef enum int {
      SLOT_YEAR, SLOT_MONTH, SLOT_DAY, SLOT_HOUR, SLOT_MINUTE, SLOT_SECOND
   } slot_type;

   // Tracks the parse of each text and holds the timestamps it should produce
   class date_time_scoreboard;
      int        pivot;
      int        count;
      phase_type phase;
      int        accum;
      int        fields[6];
      bit        bad;
      bit        ended;
      bit        compact;
      rsp_type   expected_q[$];
      int        errors;
      int        results;
      int        slash_valid;
      int        compact_valid;

      function new();
         pivot = PIVOT_RESET;
         errors = 0;
         results = 0;
         slash_valid = 0;
         compact_valid = 0;
         clear();
      endfunction

      function void clear();
         count = 0;
         phase = PH_START;
         accum = 0;
         foreach (fields[i]) fields[i] = 0;
         bad = 1'b0;
         ended = 1'b0;
         compact = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Map a two-digit year onto its century
      function int full_year(int yy);
         return (yy < pivot) ? YEAR_2000 + yy : YEAR_1900 + yy;
      endfunction

      // Finish a two-digit time field and range-check it
      function void store_time(slot_type slot, int d, int limit, phase_type next);
         int v;
         v = accum * 10 + d;
         if (v > limit) bad = 1'b1;
         fields[slot] = v;
         phase = next;
      endfunction

      function void take_byte(int c);
         bit isd;
         int d;
         int idx;
         bit ok;
         isd = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         d = isd ? c - CHAR_ZERO : 0;
         idx = count;
         ok = 1'b1;
         if (count >= TEXT_LEN_MAX) begin
            bad = 1'b1;
            return;
         end
         count++;
         case (phase)
            PH_START: begin
               if (isd) begin
                  accum = d;
                  phase = PH_LEAD2;
               end else ok = 1'b0;
            end
            PH_LEAD2: begin
               if (c == CHAR_SLASH) begin
                  if (accum < 1) ok = 1'b0;
                  fields[SLOT_MONTH] = accum;
                  phase = PH_DAY1;
               end else if (isd) begin
                  accum = accum * 10 + d;
                  phase = PH_LEAD3;
               end else ok = 1'b0;
            end
            PH_LEAD3: begin
               if (c == CHAR_SLASH) begin
                  if (accum < 1 || accum > MAX_MONTH) ok = 1'b0;
                  fields[SLOT_MONTH] = accum;
                  phase = PH_DAY1;
               end else if (isd) begin
                  // third digit in a row: compact form
                  compact = 1'b1;
                  fields[SLOT_YEAR] = accum * 10 + d;
                  phase = PH_COMPACT;
               end else ok = 1'b0;
            end
            PH_DAY1, PH_Y1: begin
               if (isd) begin
                  accum = d;
                  phase = phase_type'(phase + 1);
               end else ok = 1'b0;
            end
            PH_DAY2: begin
               if (c == CHAR_SLASH) begin
                  if (accum < 1) ok = 1'b0;
                  fields[SLOT_DAY] = accum;
                  phase = PH_Y1;
               end else if (isd) begin
                  accum = accum * 10 + d;
                  phase = PH_DAYSL;
               end else ok = 1'b0;
            end
            PH_DAYSL: begin
               if (c == CHAR_SLASH) begin
                  if (accum < 1 || accum > MAX_DAY) ok = 1'b0;
                  fields[SLOT_DAY] = accum;
                  phase = PH_Y1;
               end else ok = 1'b0;
            end
            PH_Y2, PH_Y4: begin
               if (isd) begin
                  accum = accum * 10 + d;
                  phase = (phase == PH_Y2) ? PH_Y3 : PH_YEND;
               end else ok = 1'b0;
            end
            PH_Y3: begin
               if (c == CHAR_SPACE) begin
                  fields[SLOT_YEAR] = full_year(accum);
                  phase = PH_H1;
               end else if (isd) begin
                  accum = accum * 10 + d;
                  phase = PH_Y4;
               end else ok = 1'b0;
            end
            PH_YEND: begin
               if (c == CHAR_SPACE) begin
                  fields[SLOT_YEAR] = accum;
                  phase = PH_H1;
               end else ok = 1'b0;
            end
            PH_H1, PH_M1, PH_S1: begin
               if (isd) begin
                  accum = d;
                  phase = phase_type'(phase + 1);
               end else ok = 1'b0;
            end
            PH_H2: begin
               if (isd) store_time(SLOT_HOUR, d, MAX_HOUR, PH_HC);
               else ok = 1'b0;
            end
            PH_HC: begin
               if (c == CHAR_COLON) phase = PH_M1;
               else ok = 1'b0;
            end
            PH_M2: begin
               if (isd) store_time(SLOT_MINUTE, d, MAX_MINSEC, PH_MEND);
               else ok = 1'b0;
            end
            PH_MEND: begin
               if (c == CHAR_COLON) phase = PH_S1;
               else ok = 1'b0;
            end
            PH_S2: begin
               if (isd) store_time(SLOT_SECOND, d, MAX_MINSEC, PH_SEND);
               else ok = 1'b0;
            end
            PH_COMPACT: begin
               // accumulate by position; milliseconds are dropped
               if (!isd) ok = 1'b0;
               else if (idx < POS_MONTH) fields[SLOT_YEAR] = fields[SLOT_YEAR] * 10 + d;
               else if (idx < POS_DAY) fields[SLOT_MONTH] = fields[SLOT_MONTH] * 10 + d;
               else if (idx < POS_HOUR) fields[SLOT_DAY] = fields[SLOT_DAY] * 10 + d;
               else if (idx < POS_MINUTE) fields[SLOT_HOUR] = fields[SLOT_HOUR] * 10 + d;
               else if (idx < POS_SECOND) fields[SLOT_MINUTE] = fields[SLOT_MINUTE] * 10 + d;
               else if (idx < LEN_HMS) fields[SLOT_SECOND] = fields[SLOT_SECOND] * 10 + d;
            end
            default: ok = 1'b0;
         endcase
         if (!ok) bad = 1'b1;
      endfunction

      // Advance the parse by one accepted item; on last, queue the timestamp
      function void note_item(req_type item);
         int      c;
         int      f[6];
         bit      ok;
         rsp_type want;
         c = item.text_byte;
         if (!ended) begin
            if (c == CHAR_END) ended = 1'b1;
            else if (!bad) take_byte(c);
            else if (count < TEXT_LEN_MAX) count++;
         end
         if (!item.last) return;

         f = fields;
         ok = !bad;
         case (phase)
            PH_Y3: f[SLOT_YEAR] = full_year(accum);
            PH_YEND: f[SLOT_YEAR] = accum;
            PH_MEND, PH_SEND: ;
            PH_COMPACT: begin
               ok = ok && (count == LEN_DATE || count == LEN_HM ||
                           count == LEN_HMS || count == LEN_MSEC);
               ok = ok && f[SLOT_YEAR] >= YEAR_1900;
               ok = ok && f[SLOT_MONTH] >= 1 && f[SLOT_MONTH] <= MAX_MONTH;
               ok = ok && f[SLOT_DAY] >= 1 && f[SLOT_DAY] <= MAX_DAY;
               ok = ok && f[SLOT_HOUR] <= MAX_HOUR && f[SLOT_MINUTE] <= MAX_MINSEC &&
                    f[SLOT_SECOND] <= MAX_MINSEC;
            end
            default: ok = 1'b0;
         endcase

         want = '0;
         if (ok) begin
            want.valid_res = 1'b1;
            want.text_form = compact;
            want.year = 14'(f[SLOT_YEAR]);
            want.month = 4'(f[SLOT_MONTH]);
            want.day = 5'(f[SLOT_DAY]);
            want.hour = 5'(f[SLOT_HOUR]);
            want.minute = 6'(f[SLOT_MINUTE]);
            want.second = 6'(f[SLOT_SECOND]);
         end
         expected_q.push_back(want);
         clear();
      endfunction

      function void check_field(string name, logic [13:0] want_v, logic [13:0] got_v);
         if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
         end
      endfunction

      // Compare one accepted timestamp with the oldest one queued
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with no text pending: expected none, got %h", $time, got);
            return;
         end
         want = expected_q.pop_front();
         results++;
         if (want.valid_res) begin
            if (want.text_form) compact_valid++;
            else slash_valid++;
         end
         check_field("valid_res", want.valid_res, got.valid_res);
         check_field("text_form", want.text_form, got.text_form);
         check_field("year", want.year, got.year);
         check_field("month", want.month, got.month);
         check_field("day", want.day, got.day);
         check_field("hour", want.hour, got.hour);
         check_field("minute", want.minute, got.minute);
         check_field("second", want.second, got.second);
      endfunction
   endclass

endpackage

FILE: tb/tb.sv
module tb;
   import dtp_pkg::*;
   import dtp_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 205;
   localparam int SETTLE_CYCLES  = 4;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_data;
   logic               csr_wr_en;
   logic [PIVOT_W-1:0] csr_wr_data;

   date_time_scoreboard board;
   logic [7:0]          text_buf[$];
   int                  send_idle_pct;
   int                  recv_idle_pct;
   int                  texts_sent;
   int                  bytes_sent;
   int                  quiet_cycles;
   int                  pivot_list[6];

   string directed_texts[] = '{
      "1/2/03", "12/31/1999 23:59:59", "12/05/49", "6/7/50 00:00",
      "0/5/20", "13/1/20", "1/0/20", "1/32/20", "1/1/20 24:00",
      "1/1/20 12:60", "1/1/20 12:00:60", "1/1/20 12:00:00:", "1/1/20 ",
      "1/1/2", "ab/1/20", "19000101", "18991231", "20001301", "20000100",
      "200001012400", "99991231235959", "20000101000000999", "2000010112",
      "1999010112345612345678901"
   };

   date_time_text_parser_top #(
      .MAX_TEXT_LEN(TEXT_LEN_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Text building
   function void put_str(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function void put_num(int v, int digits);
      int div;
      div = 1;
      repeat (digits - 1) div *= 10;
      repeat (digits) begin
         text_buf.push_back(8'(CHAR_ZERO + (v / div) % 10));
         div /= 10;
      end
   endfunction

   function int pick(int lo, int hi, int wild_pct);
      return ($urandom_range(99) < wild_pct) ? $urandom_range(99) : $urandom_range(hi, lo);
   endfunction

   function logic [7:0] rand_digit();
      return 8'(CHAR_ZERO + $urandom_range(9));
   endfunction

   function void build_slash();
      int mon;
      int dy;
      mon = pick(1, 12, 10);
      dy = pick(1, 31, 10);
      put_num(mon, (mon < 10) ? $urandom_range(2, 1) : 2);
      text_buf.push_back(CHAR_SLASH);
      put_num(dy, (dy < 10) ? $urandom_range(2, 1) : 2);
      text_buf.push_back(CHAR_SLASH);
      if ($urandom_range(1)) put_num($urandom_range(99), 2);
      else put_num($urandom_range(9999), 4);
      if ($urandom_range(1)) begin
         text_buf.push_back(CHAR_SPACE);
         put_num(pick(0, 23, 10), 2);
         text_buf.push_back(CHAR_COLON);
         put_num(pick(0, 59, 10), 2);
         if ($urandom_range(1)) begin
            text_buf.push_back(CHAR_COLON);
            put_num(pick(0, 59, 10), 2);
         end
      end
   endfunction

   function void build_compact();
      int len;
      put_num(($urandom_range(9) == 0) ? $urandom_range(1899) : $urandom_range(9999, 1900), 4);
      put_num(pick(1, 12, 10), 2);
      put_num(pick(1, 31, 10), 2);
      put_num(pick(0, 23, 10), 2);
      put_num(pick(0, 59, 10), 2);
      put_num(pick(0, 59, 10), 2);
      put_num($urandom_range(999), 3);
      case ($urandom_range(7))
         0:       len = $urandom_range(20, 1);
         1, 2:    len = LEN_DATE;
         3, 4:    len = LEN_HM;
         5:       len = LEN_HMS;
         default: len = LEN_MSEC;
      endcase
      while (text_buf.size() > len) void'(text_buf.pop_back());
      while (text_buf.size() < len) text_buf.push_back(rand_digit());
   endfunction

   // Break a well-formed text in one place
   function void mangle();
      int pos;
      pos = $urandom_range(text_buf.size() - 1);
      case ($urandom_range(3))
         0: text_buf[pos] = 8'($urandom_range(255));
         1: begin
            case ($urandom_range(3))
               0: text_buf[pos] = CHAR_SLASH;
               1: text_buf[pos] = CHAR_SPACE;
               2: text_buf[pos] = CHAR_COLON;
               default: text_buf[pos] = rand_digit();
            endcase
         end
         2: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
         default: if (text_buf.size() > 1) text_buf.delete(pos);
      endcase
   endfunction

   function void build_text();
      int kind;
      kind = $urandom_range(99);
      if (kind < 42) build_slash();
      else if (kind < 80) build_compact();
      else if (kind < 88) repeat ($urandom_range(28, 1)) text_buf.push_back(8'($urandom_range(255)));
      else if (kind < 93) repeat ($urandom_range(30, 25)) text_buf.push_back(rand_digit());
      else begin
         repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(2))
               0: text_buf.push_back(CHAR_END);
               1: text_buf.push_back(CHAR_SLASH);
               default: text_buf.push_back(rand_digit());
            endcase
         end
      end
      if (kind < 80 && $urandom_range(99) < 20) mangle();
      // terminate early and trail some ignored bytes
      if ($urandom_range(99) < 15) begin
         text_buf.push_back(CHAR_END);
         repeat ($urandom_range(4)) text_buf.push_back(8'($urandom_range(255)));
      end
   endfunction

   // Drive one item and return at the edge that accepts it
   task send_byte(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      board.note_item(item);
      bytes_sent++;
   endtask

   task send_text();
      req_type item;
      for (int i = 0; i < text_buf.size(); i++) begin
         item.text_byte = text_buf[i];
         item.last = (i == text_buf.size() - 1);
         send_byte(item);
      end
      text_buf.delete();
      texts_sent++;
   endtask

   // Drop valid and wait until every queued timestamp has come out
   task settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_pivot(input int v);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= PIVOT_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.pivot = v;
   endtask

   // Receive timestamps and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Stop a run that no longer moves
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : main
      int phase_start;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 38;
      recv_idle_pct = 50;
      texts_sent = 0;
      bytes_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts at the reset pivot
      foreach (directed_texts[i]) begin
         put_str(directed_texts[i]);
         send_text();
      end
      text_buf.push_back(CHAR_END);
      send_text();
      put_str("1/1/20");
      text_buf.push_back(CHAR_END);
      text_buf.push_back(8'hFF);
      text_buf.push_back(rand_digit());
      send_text();
      text_buf.push_back(8'h80);
      send_text();

      // Random texts over pivot settings and stall patterns
      pivot_list = '{0, 99, 127, 1, $urandom_range(98, 2), 50};
      for (int p = 0; p < 6; p++) begin
         write_pivot(pivot_list[p]);
         case (p / 2)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_text();
            send_text();
         end
      end
      settle();

      $display("Sent %0d texts in %0d bytes over six pivot settings and three stall patterns.",
               texts_sent, bytes_sent);
      $display("Checked %0d timestamps: %0d valid slash form, %0d valid compact form.",
               board.results, board.slash_valid, board.compact_valid);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: date_time_text_parser_top.f
rtl/core/dtp_pkg.sv
rtl/core/dtp_parse.sv
rtl/core/dtp_check.sv
rtl/core/date_time_text_parser_top.sv
tb/dtp_tb_pkg.sv
tb/tb.sv
